FILE: sv/onps_pkg.sv
`default_nettype none

package onps_pkg;

   // default sizes of the point store and coordinates
   localparam int DEF_MAX_POINTS = 1024;
   localparam int DEF_COORD_BITS = 24;

   // fixed field widths
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int IDX_OUT_W  = 10;
   localparam int OCT_W      = 3;
   localparam int RSP_W      = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int DIST_SAT_W = 64;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_MID_X = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MID_Y = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MID_Z = 2'd2;

   // control that travels with each operand through the squaring unit
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } sq_ctrl_type;

endpackage

`default_nettype wire

FILE: sv/octant_nearest_point_search.sv
`default_nettype none

// channel | dir | fields in tdata (low bit up)                          | role
// req_    | in  | cmd[2], coord_x, coord_y, coord_z (COORD_BITS each)   | load/query/clear
// rsp_    | out | status[2], nearest_index[10], zero fill to 16 bits     | one per request
// csr_    | in  | index 0 mid_x, 1 mid_y, 2 mid_z                        | midpoint writes
//
// load, clear and unused commands go straight from idle to the response state.
// a query scans every stored point: the M points of its octant go through the
// shared squaring unit one axis a cycle, the K other points take one ram read each.
// req_tready is high only in idle; the result register lets a new request in while
// a result waits. reset is synchronous and empties the store; no clearing pass.

module octant_nearest_point_search
   import onps_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_tvalid,
   output logic                                         req_tready,
   // cmd, coord_x, coord_y, coord_z, zero fill
   input  wire logic [((CMD_W+3*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready,
   // status, nearest_index, zero fill
   output logic      [RSP_W-1:0]                        rsp_tdata,
   input  wire logic                                    csr_wr_en,
   input  wire logic [CSR_ADDR_W-1:0]                   csr_addr,
   input  wire logic [COORD_BITS-1:0]                   csr_wdata
);

   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int WORD_W = 3*COORD_BITS + OCT_W;
   localparam int SQ_W   = 2*COORD_BITS;
   localparam int SUM_W  = 2*COORD_BITS + 2;
   localparam int DIST_W = (SUM_W > DIST_SAT_W) ? DIST_SAT_W : SUM_W;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_SUM_Y = 6'b000100,
      S_SUM_Z = 6'b001000,
      S_DRAIN = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type                    state_ff, state_in;
   logic        [CNT_W-1:0]      count_ff, count_in;
   logic        [IDX_W-1:0]      idx_ff, idx_in;
   logic        [CNT_W-1:0]      next_idx;
   logic                         more;
   logic signed [COORD_BITS-1:0] mid_x_ff, mid_y_ff, mid_z_ff;
   logic signed [COORD_BITS-1:0] q_x_ff, q_y_ff, q_z_ff;
   logic        [OCT_W-1:0]      q_oct_ff;
   logic        [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic        [IDX_OUT_W-1:0]  res_idx_ff, res_idx_in;
   logic                         rsp_valid_ff;
   logic        [RSP_W-1:0]      rsp_data_ff;
   logic                         rsp_load;

   logic        [CMD_W-1:0]      req_cmd;
   logic signed [COORD_BITS-1:0] req_x, req_y, req_z;
   logic        [OCT_W-1:0]      req_oct;
   logic                         req_accept;

   logic                         wr_en, rd_en;
   logic        [WORD_W-1:0]     rd_data;
   logic        [COORD_BITS-1:0] rd_x, rd_y, rd_z;
   logic        [OCT_W-1:0]      rd_oct;

   sq_ctrl_type                  sq_in_ctrl, sq_out_ctrl;
   logic        [COORD_BITS-1:0] op_a, op_b;
   logic        [SQ_W-1:0]       sq_out;
   logic        [IDX_W-1:0]      sq_out_tag;
   logic                         sq_busy;

   logic        [SUM_W-1:0]      acc_ff;
   logic        [SUM_W-1:0]      total;
   logic        [DIST_W-1:0]     dist_sat;
   logic        [DIST_W-1:0]     best_dist_ff;
   logic        [IDX_W-1:0]      best_idx_ff;
   logic                         found_ff;
   logic                         better;

   // request fields and octant against the current midpoint
   assign req_cmd    = req_tdata[CMD_W-1:0];
   assign req_x      = req_tdata[CMD_W +: COORD_BITS];
   assign req_y      = req_tdata[CMD_W+COORD_BITS +: COORD_BITS];
   assign req_z      = req_tdata[CMD_W+2*COORD_BITS +: COORD_BITS];
   assign req_oct    = {req_x > mid_x_ff, req_y > mid_y_ff, req_z > mid_z_ff};
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid & req_tready;

   // stored word fields
   assign rd_x   = rd_data[0 +: COORD_BITS];
   assign rd_y   = rd_data[COORD_BITS +: COORD_BITS];
   assign rd_z   = rd_data[2*COORD_BITS +: COORD_BITS];
   assign rd_oct = rd_data[3*COORD_BITS +: OCT_W];

   assign next_idx = CNT_W'(idx_ff) + 1'b1;
   assign more     = next_idx < count_ff;

   // midpoint registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_x_ff <= '0;
         mid_y_ff <= '0;
         mid_z_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_MID_X: mid_x_ff <= csr_wdata;
            CSR_MID_Y: mid_y_ff <= csr_wdata;
            CSR_MID_Z: mid_z_ff <= csr_wdata;
            default:   ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      sq_in_ctrl    = '0;
      op_a          = q_x_ff;
      op_b          = rd_x;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in      = S_RESP;
               res_status_in = ST_DONE;
               res_idx_in    = '0;
               unique case (req_cmd)
                  CMD_LOAD: begin
                     if (count_ff == CNT_W'(MAX_POINTS)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        wr_en      = 1'b1;
                        count_in   = count_ff + 1'b1;
                        res_idx_in = IDX_OUT_W'(count_ff);
                     end
                  end
                  CMD_QUERY: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_NONE;
                     end else begin
                        idx_in   = '0;
                        rd_en    = 1'b1;
                        state_in = S_CHECK;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            if (rd_oct == q_oct_ff) begin
               sq_in_ctrl.valid = 1'b1;
               sq_in_ctrl.first = 1'b1;
               state_in         = S_SUM_Y;
            end else if (more) begin
               idx_in = next_idx[IDX_W-1:0];
               rd_en  = 1'b1;
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_SUM_Y: begin
            sq_in_ctrl.valid = 1'b1;
            op_a             = q_y_ff;
            op_b             = rd_y;
            state_in         = S_SUM_Z;
         end
         S_SUM_Z: begin
            sq_in_ctrl.valid = 1'b1;
            sq_in_ctrl.last  = 1'b1;
            op_a             = q_z_ff;
            op_b             = rd_z;
            if (more) begin
               idx_in   = next_idx[IDX_W-1:0];
               rd_en    = 1'b1;
               state_in = S_CHECK;
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!sq_busy) begin
               res_status_in = found_ff ? ST_DONE : ST_NONE;
               res_idx_in    = found_ff ? IDX_OUT_W'(best_idx_ff) : '0;
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // query operands and pending result
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      if (req_accept) begin
         q_x_ff   <= req_x;
         q_y_ff   <= req_y;
         q_z_ff   <= req_z;
         q_oct_ff <= req_oct;
      end
   end

   // point store: {octant, z, y, x}
   onps_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({req_oct, req_z, req_y, req_x}),
      .rd_en   (rd_en),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   // shared squared-difference unit, one axis per cycle
   onps_sq_unit #(
      .COORD_BITS (COORD_BITS),
      .TAG_W      (IDX_W)
   ) u_sq (
      .clock    (clock),
      .reset    (reset),
      .in_ctrl  (sq_in_ctrl),
      .in_a     (op_a),
      .in_b     (op_b),
      .in_tag   (idx_ff),
      .out_ctrl (sq_out_ctrl),
      .out_sq   (sq_out),
      .out_tag  (sq_out_tag),
      .busy     (sq_busy)
   );

   // distance sum, saturated, and strict-less compare so the lowest index wins ties
   always_comb begin
      total    = acc_ff + SUM_W'(sq_out);
      dist_sat = (|(total >> DIST_W)) ? '1 : total[DIST_W-1:0];
      better   = !found_ff || (dist_sat < best_dist_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (req_accept && req_cmd == CMD_QUERY) begin
         found_ff <= 1'b0;
      end else if (sq_out_ctrl.valid && sq_out_ctrl.last && better) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (sq_out_ctrl.valid) begin
         if (sq_out_ctrl.first) begin
            acc_ff <= SUM_W'(sq_out);
         end else if (sq_out_ctrl.last) begin
            if (better) begin
               best_dist_ff <= dist_sat;
               best_idx_ff  <= sq_out_tag;
            end
         end else begin
            acc_ff <= total;
         end
      end
   end

   // result register
   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= RSP_W'({res_idx_ff, res_status_ff});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store depth");

   a_idle_unit_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !sq_busy)
      else $error("squaring unit busy while idle");

   a_tag_in_store: assert property (@(posedge clock) disable iff (reset)
      sq_out_ctrl.valid |-> (CNT_W'(sq_out_tag) < count_ff))
      else $error("scanned index outside stored points");

   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN && !sq_busy) |=> (state_ff == S_RESP))
      else $error("drain did not hand over the result");
`endif

endmodule

`default_nettype wire

FILE: sv/onps_ram.sv
`default_nettype none

module onps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: sv/onps_sq_unit.sv
`default_nettype none

module onps_sq_unit
   import onps_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int TAG_W      = 10
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sq_ctrl_type             in_ctrl,
   input  wire logic [COORD_BITS-1:0]   in_a,
   input  wire logic [COORD_BITS-1:0]   in_b,
   input  wire logic [TAG_W-1:0]        in_tag,
   output sq_ctrl_type                  out_ctrl,
   output logic      [2*COORD_BITS-1:0] out_sq,
   output logic      [TAG_W-1:0]        out_tag,
   output logic                         busy
);

   sq_ctrl_type                  mag_ctrl_ff;
   logic        [COORD_BITS-1:0] mag_ff;
   logic        [COORD_BITS-1:0] mag_in;
   logic        [TAG_W-1:0]      mag_tag_ff;
   sq_ctrl_type                  sq_ctrl_ff;
   logic      [2*COORD_BITS-1:0] sq_ff;
   logic      [2*COORD_BITS-1:0] sq_in;
   logic        [TAG_W-1:0]      sq_tag_ff;
   logic signed [COORD_BITS:0]   diff;
   logic        [COORD_BITS:0]   mag_full;

   // stage 1: absolute difference, fits coordinate width
   always_comb begin
      diff     = $signed({in_a[COORD_BITS-1], in_a}) - $signed({in_b[COORD_BITS-1], in_b});
      mag_full = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
      mag_in   = mag_full[COORD_BITS-1:0];
   end

   // stage 2: square of the magnitude
   assign sq_in = (2*COORD_BITS)'(mag_ff) * (2*COORD_BITS)'(mag_ff);

   // control pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ctrl_ff <= '0;
         sq_ctrl_ff  <= '0;
      end else begin
         mag_ctrl_ff <= in_ctrl;
         sq_ctrl_ff  <= mag_ctrl_ff;
      end
   end

   // data pipeline
   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      mag_tag_ff <= in_tag;
      sq_ff      <= sq_in;
      sq_tag_ff  <= mag_tag_ff;
   end

   assign out_ctrl = sq_ctrl_ff;
   assign out_sq   = sq_ff;
   assign out_tag  = sq_tag_ff;
   assign busy     = mag_ctrl_ff.valid | sq_ctrl_ff.valid;

endmodule

`default_nettype wire
